/* src/salc_pkg.sv */
// Shared types and constants of the set-associative LRU cache tag unit.
package salc_pkg;

    // Controller states, one-hot coded.
    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_READ  = 5'b00100,
        ST_WRITE = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    // Register indexes on the configuration port (byte address / 4).
    localparam logic [1:0] REG_OFFSET_WIDTH = 2'd0;
    localparam logic [1:0] REG_INDEX_WIDTH  = 2'd1;
    localparam logic [1:0] REG_WAYS         = 2'd2;

    // Register reset values and field limits.
    localparam logic [3:0] OFFSET_RESET = 4'd5;
    localparam logic [3:0] INDEX_RESET  = 4'd5;
    localparam logic [3:0] WAYS_RESET   = 4'd4;
    localparam logic [3:0] OFFSET_MAX   = 4'd12;
    localparam logic [3:0] INDEX_MAX    = 4'd10;

    // Statistics counters.
    localparam int unsigned CNT_W = 48;
    localparam logic [CNT_W-1:0] CNT_TOP = '1;

    // Result item layout in m_tdata, lowest bit first.
    localparam int unsigned RES_HIT   = 0;
    localparam int unsigned RES_WAY   = 1;
    localparam int unsigned RES_WB    = 4;
    localparam int unsigned RES_VTAG  = 5;
    localparam int unsigned RES_ACC   = 37;
    localparam int unsigned RES_RH    = RES_ACC + CNT_W;
    localparam int unsigned RES_WH    = RES_RH + CNT_W;
    localparam int unsigned RES_RM    = RES_WH + CNT_W;
    localparam int unsigned RES_WM    = RES_RM + CNT_W;
    localparam int unsigned RES_WBC   = RES_WM + CNT_W;
    localparam int unsigned RES_BITS  = RES_WBC + CNT_W;
    localparam int unsigned RES_W     = ((RES_BITS + 7) / 8) * 8;

endpackage

/* src/salc_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module salc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                                     aclk,
    input  logic                                     we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* src/set_assoc_lru_cache_tags_unit.sv */
// Top level of the set-associative LRU write-back cache tag and state controller.
//
//  Channel   Direction  Handshake          Content
//  s_        in         tvalid / tready    tdata: address; tuser: func
//  m_        out        tvalid / tready    tdata: hit, way, writeback, victim_tag, counters
//  APB       in         psel/penable/pready offset width, index width, ways in use
//
// For each item the ways of its set are read one per cycle through the registered
// RAM read port, then written back one per cycle; the done state then loads the
// result, and the idle state accepts the next item.
// After reset a clearing pass writes all MAX_LINES entries, one per cycle, before
// the first item is accepted. A result that is not taken holds the unit in its
// done state once the next result is ready.
// The next item is accepted while a finished result waits in the output register.
module set_assoc_lru_cache_tags_unit
    import salc_pkg::*;
#(
    parameter int unsigned MAX_LINES = 1024,
    parameter int unsigned MAX_WAYS  = 8,
    parameter int unsigned AGE_WIDTH = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    // Input items
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [31:0]        s_tdata,   // [31:0] address
    input  logic               s_tuser,   // [0] func
    // Result items
    output logic               m_tvalid,
    input  logic               m_tready,
    // [0] hit, [3:1] way, [4] writeback, [36:5] victim_tag, [84:37] access_count,
    // [132:85] read_hit_count, [180:133] write_hit_count, [228:181] read_miss_count,
    // [276:229] write_miss_count, [324:277] writeback_count, [327:325] zero
    output logic [RES_W-1:0]   m_tdata,
    // Configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int unsigned LW   = MAX_LINES > 1 ? $clog2(MAX_LINES) : 1;
    localparam int unsigned NW_W = $clog2(MAX_WAYS + 1);
    localparam int unsigned WIX  = MAX_WAYS > 1 ? $clog2(MAX_WAYS) : 1;
    localparam int unsigned EW   = 34 + AGE_WIDTH;
    localparam logic [AGE_WIDTH-1:0] AGE_TOP = '1;

    // Configuration registers
    logic [3:0] offset_reg, index_reg, ways_reg;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= OFFSET_RESET;
            index_reg  <= INDEX_RESET;
            ways_reg   <= WAYS_RESET;
        end else if (cfg_wr && paddr[1:0] == 2'b00) begin
            unique case (paddr[3:2])
                REG_OFFSET_WIDTH: offset_reg <= pwdata[3:0];
                REG_INDEX_WIDTH:  index_reg  <= pwdata[3:0];
                REG_WAYS:         ways_reg   <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        prdata = '0;
        unique case (paddr[3:2])
            REG_OFFSET_WIDTH: prdata = {28'd0, offset_reg};
            REG_INDEX_WIDTH:  prdata = {28'd0, index_reg};
            REG_WAYS:         prdata = {28'd0, ways_reg};
            default:          prdata = '0;
        endcase
    end

    // Effective geometry of the incoming item
    logic [3:0]      ob, ibc, ib;
    logic [NW_W-1:0] nw;
    logic [31:0]     new_tag;
    logic [9:0]      set_idx;
    logic [15:0]     base_full;

    always_comb begin
        ob  = offset_reg > OFFSET_MAX ? OFFSET_MAX : offset_reg;
        ibc = index_reg > INDEX_MAX ? INDEX_MAX : index_reg;
        if (ways_reg == 4'd0) begin
            nw = NW_W'(1);
        end else if (32'(ways_reg) > MAX_WAYS) begin
            nw = NW_W'(MAX_WAYS);
        end else begin
            nw = NW_W'(ways_reg);
        end
        if (32'(nw) > MAX_LINES) begin
            nw = NW_W'(MAX_LINES);
        end
        // Largest index width that fits storage, not above the requested one.
        ib = 4'd0;
        for (int i = 1; i <= 10; i++) begin
            if (4'(i) <= ibc && ((32'(nw) << i) <= 32'(MAX_LINES))) begin
                ib = 4'(i);
            end
        end
        new_tag   = s_tdata >> (5'(ob) + 5'(ib));
        set_idx   = 10'((s_tdata >> ob) & ((32'd1 << ib) - 32'd1));
        base_full = 16'(set_idx) * 16'(nw);
    end

    // Controller state
    state_t          state_reg, state_next;
    logic [LW-1:0]   clr_reg;
    logic [NW_W-1:0] nw_reg, rd_cnt_reg, wr_cnt_reg;
    logic [LW-1:0]   base_reg;
    logic [31:0]     tag_reg;
    logic            wr_reg;
    logic            pend_reg;
    logic [WIX-1:0]  pend_way_reg;
    logic            hit_reg;
    logic [WIX-1:0]  hway_reg, vway_reg, way_reg;
    logic [AGE_WIDTH-1:0] max_age_reg;
    logic [31:0]     vtag_reg;
    logic            vvalid_reg, vdirty_reg;
    logic [EW-1:0]   ent_reg [MAX_WAYS];

    logic [CNT_W-1:0] acc_reg, rh_reg, wh_reg, rm_reg, wm_reg, wbc_reg;
    logic             out_vld_reg;
    logic [RES_W-1:0] out_reg;

    // Memory ports
    logic            mem_we;
    logic [LW-1:0]   mem_waddr, mem_raddr;
    logic [EW-1:0]   mem_wdata, mem_rdata;

    salc_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_LINES)
    ) u_lines (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Search updates on the entry that arrives from memory
    logic            cap_hit;
    logic            cap_vic;
    logic            hit_next;
    logic [WIX-1:0]  hway_next, vway_next;
    logic            last_cap;
    logic            s_acc, load_out;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign load_out = (state_reg == ST_DONE) && (!out_vld_reg || m_tready);

    always_comb begin
        cap_hit   = pend_reg && !hit_reg && mem_rdata[32] && (mem_rdata[31:0] == tag_reg);
        cap_vic   = pend_reg && (pend_way_reg == '0 || mem_rdata[EW-1:34] > max_age_reg);
        hit_next  = hit_reg || cap_hit;
        hway_next = cap_hit ? pend_way_reg : hway_reg;
        vway_next = cap_vic ? pend_way_reg : vway_reg;
        last_cap  = pend_reg && (NW_W'(pend_way_reg) == nw_reg - NW_W'(1));
    end

    // Memory access sequencing
    logic [EW-1:0]        wr_ent;
    logic [AGE_WIDTH-1:0] wr_age;
    logic                 wr_sel;

    always_comb begin
        wr_ent    = ent_reg[WIX'(wr_cnt_reg)];
        wr_sel    = (WIX'(wr_cnt_reg) == way_reg);
        wr_age    = wr_ent[EW-1:34] == AGE_TOP ? AGE_TOP : wr_ent[EW-1:34] + 1'b1;
        mem_we    = 1'b0;
        mem_waddr = base_reg + LW'(wr_cnt_reg);
        mem_wdata = {wr_age, wr_ent[33:0]};
        mem_raddr = base_reg + LW'(rd_cnt_reg);
        unique case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = {{AGE_WIDTH{1'b0}}, 2'b00, 32'hFFFF_FFFF};
            end
            ST_WRITE: begin
                mem_we = 1'b1;
                if (wr_sel) begin
                    if (hit_reg) begin
                        mem_wdata = {{AGE_WIDTH{1'b0}}, wr_ent[33] | wr_reg, wr_ent[32:0]};
                    end else begin
                        mem_wdata = {{AGE_WIDTH{1'b0}}, wr_reg, 1'b1, tag_reg};
                    end
                end
            end
            default: ;
        endcase
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (clr_reg == LW'(MAX_LINES - 1)) state_next = ST_IDLE;
            ST_IDLE:  if (s_acc) state_next = ST_READ;
            ST_READ:  if (last_cap) state_next = ST_WRITE;
            ST_WRITE: if (wr_cnt_reg == nw_reg - NW_W'(1)) state_next = ST_DONE;
            ST_DONE:  if (load_out) state_next = ST_IDLE;
            default:  state_next = ST_CLEAR;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            pend_reg    <= 1'b0;
            out_vld_reg <= 1'b0;
            acc_reg     <= '0;
            rh_reg      <= '0;
            wh_reg      <= '0;
            rm_reg      <= '0;
            wm_reg      <= '0;
            wbc_reg     <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_reg <= clr_reg + 1'b1;
            end
            pend_reg <= (state_reg == ST_READ) && (rd_cnt_reg < nw_reg);
            if (load_out) begin
                out_vld_reg <= 1'b1;
                acc_reg <= acc_reg == CNT_TOP ? acc_reg : acc_reg + 1'b1;
                if (hit_reg && !wr_reg) rh_reg <= rh_reg == CNT_TOP ? rh_reg : rh_reg + 1'b1;
                if (hit_reg && wr_reg)  wh_reg <= wh_reg == CNT_TOP ? wh_reg : wh_reg + 1'b1;
                if (!hit_reg && !wr_reg) rm_reg <= rm_reg == CNT_TOP ? rm_reg : rm_reg + 1'b1;
                if (!hit_reg && wr_reg)  wm_reg <= wm_reg == CNT_TOP ? wm_reg : wm_reg + 1'b1;
                if (!hit_reg && vvalid_reg && vdirty_reg) begin
                    wbc_reg <= wbc_reg == CNT_TOP ? wbc_reg : wbc_reg + 1'b1;
                end
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Item payload and search registers
    logic             res_wb;
    logic [CNT_W-1:0] acc_n, rh_n, wh_n, rm_n, wm_n, wbc_n;

    always_comb begin
        res_wb = !hit_reg && vvalid_reg && vdirty_reg;
        acc_n  = acc_reg == CNT_TOP ? acc_reg : acc_reg + 1'b1;
        rh_n   = (hit_reg && !wr_reg && rh_reg != CNT_TOP) ? rh_reg + 1'b1 : rh_reg;
        wh_n   = (hit_reg && wr_reg && wh_reg != CNT_TOP) ? wh_reg + 1'b1 : wh_reg;
        rm_n   = (!hit_reg && !wr_reg && rm_reg != CNT_TOP) ? rm_reg + 1'b1 : rm_reg;
        wm_n   = (!hit_reg && wr_reg && wm_reg != CNT_TOP) ? wm_reg + 1'b1 : wm_reg;
        wbc_n  = (res_wb && wbc_reg != CNT_TOP) ? wbc_reg + 1'b1 : wbc_reg;
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            nw_reg      <= nw;
            base_reg    <= LW'(base_full);
            tag_reg     <= new_tag;
            wr_reg      <= s_tuser;
            rd_cnt_reg  <= '0;
            wr_cnt_reg  <= '0;
            hit_reg     <= 1'b0;
            hway_reg    <= '0;
            vway_reg    <= '0;
            max_age_reg <= '0;
            vtag_reg    <= '0;
            vvalid_reg  <= 1'b0;
            vdirty_reg  <= 1'b0;
        end
        if (state_reg == ST_READ) begin
            if (rd_cnt_reg < nw_reg) begin
                rd_cnt_reg   <= rd_cnt_reg + 1'b1;
                pend_way_reg <= WIX'(rd_cnt_reg);
            end
            if (pend_reg) begin
                ent_reg[pend_way_reg] <= mem_rdata;
                hit_reg  <= hit_next;
                hway_reg <= hway_next;
                if (cap_vic) begin
                    vway_reg    <= pend_way_reg;
                    max_age_reg <= mem_rdata[EW-1:34];
                    vtag_reg    <= mem_rdata[31:0];
                    vvalid_reg  <= mem_rdata[32];
                    vdirty_reg  <= mem_rdata[33];
                end
            end
            if (last_cap) begin
                way_reg <= hit_next ? hway_next : vway_next;
            end
        end
        if (state_reg == ST_WRITE) begin
            wr_cnt_reg <= wr_cnt_reg + 1'b1;
        end
        if (load_out) begin
            out_reg <= RES_W'({wbc_n, wm_n, rm_n, wh_n, rh_n, acc_n,
                               res_wb ? vtag_reg : 32'd0, res_wb,
                               3'(way_reg), hit_reg});
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_reg;

endmodule

/* src/salc_checker.sv */
// Port-level checker for the cache tag unit and its bind statement.
module salc_checker
    import salc_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [RES_W-1:0] m_tdata
);

    // A result stays offered until it is taken.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped before it was taken");

    // One item at a time: no acceptance right after an acceptance.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item accepted while busy");

    // A hit never evicts a line.
    a_hit_no_wb: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[RES_HIT] |-> !m_tdata[RES_WB])
        else $error("writeback reported on a hit");

    // The victim tag reads zero unless a writeback happened.
    a_vtag_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[RES_WB] |-> m_tdata[RES_VTAG +: 32] == 32'd0)
        else $error("victim tag without writeback");

endmodule

bind set_assoc_lru_cache_tags_unit salc_checker u_salc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* bench/set_assoc_lru_cache_tags_unit_test.sv */
// Self-checking testbench of the set-associative LRU cache tag unit.
`timescale 1ns / 100ps

module set_assoc_lru_cache_tags_unit_test;
    import salc_pkg::*;

    localparam int unsigned LINES   = 1024;
    localparam int unsigned WAYS_HW = 8;
    localparam logic [47:0] CNT_SAT = '1;
    localparam logic [31:0] AGE_SAT = '1;

    // One access outcome with all counters.
    typedef struct packed {
        logic [47:0] wb_cnt;
        logic [47:0] wm_cnt;
        logic [47:0] rm_cnt;
        logic [47:0] wh_cnt;
        logic [47:0] rh_cnt;
        logic [47:0] acc_cnt;
        logic [31:0] vtag;
        logic        wb;
        logic [2:0]  way;
        logic        hit;
    } access_result_t;

    // Cache tag model and the queue of outcomes it predicts.
    class cache_scoreboard;
        logic [31:0] tags [LINES];
        bit          valid [LINES];
        bit          dirty [LINES];
        logic [31:0] age [LINES];
        logic [47:0] n_acc, n_rh, n_wh, n_rm, n_wm, n_wb;
        logic [3:0]  off_reg, idx_reg, ways_reg;
        access_result_t pending[$];
        int errors;
        int checked;
        int hits_seen;
        int wbs_seen;

        function new();
            for (int i = 0; i < LINES; i++) begin
                tags[i] = '1;
                valid[i] = 0;
                dirty[i] = 0;
                age[i] = 0;
            end
            n_acc = 0; n_rh = 0; n_wh = 0; n_rm = 0; n_wm = 0; n_wb = 0;
            off_reg = OFFSET_RESET;
            idx_reg = INDEX_RESET;
            ways_reg = WAYS_RESET;
            errors = 0;
            checked = 0;
            hits_seen = 0;
            wbs_seen = 0;
        endfunction

        function logic [47:0] bump(logic [47:0] v);
            return (v == CNT_SAT) ? v : v + 48'd1;
        endfunction

        function void age_set(int unsigned base, int unsigned nw, int unsigned used);
            for (int unsigned w = 0; w < nw; w++) begin
                if (base + w < LINES) begin
                    if (w == used) age[base + w] = 0;
                    else if (age[base + w] != AGE_SAT) age[base + w] = age[base + w] + 1;
                end
            end
        endfunction

        // Note an accepted access and predict its outcome.
        function void note_access(bit is_wr, logic [31:0] addr);
            int unsigned ob, ib, nw, set_no, base, victim, ln;
            logic [31:0] tag;
            access_result_t r;
            r = '0;
            ob = (off_reg > OFFSET_MAX) ? OFFSET_MAX : off_reg;
            ib = (idx_reg > INDEX_MAX) ? INDEX_MAX : idx_reg;
            nw = (ways_reg == 0) ? 1 : ways_reg;
            if (nw > WAYS_HW) nw = WAYS_HW;
            while (ib > 0 && (nw << ib) > LINES) ib--;
            tag = 32'((64'(addr)) >> (ob + ib));
            set_no = (addr >> ob) & ((1 << ib) - 1);
            base = set_no * nw;
            n_acc = bump(n_acc);
            for (int unsigned w = 0; w < nw; w++) begin
                if (!r.hit && base + w < LINES && valid[base + w] && tags[base + w] == tag) begin
                    r.hit = 1'b1;
                    r.way = 3'(w);
                end
            end
            if (r.hit) begin
                age_set(base, nw, r.way);
                if (is_wr) begin
                    n_wh = bump(n_wh);
                    dirty[base + r.way] = 1;
                end else begin
                    n_rh = bump(n_rh);
                end
            end else begin
                victim = 0;
                for (int unsigned w = 1; w < nw; w++)
                    if (base + w < LINES && age[base + w] > age[base + victim]) victim = w;
                r.way = 3'(victim);
                ln = base + victim;
                if (ln < LINES) begin
                    if (valid[ln] && dirty[ln]) begin
                        r.wb = 1'b1;
                        r.vtag = tags[ln];
                        n_wb = bump(n_wb);
                    end
                    tags[ln] = tag;
                    valid[ln] = 1;
                    dirty[ln] = is_wr;
                end
                age_set(base, nw, victim);
                if (is_wr) n_wm = bump(n_wm);
                else n_rm = bump(n_rm);
            end
            r.acc_cnt = n_acc; r.rh_cnt = n_rh; r.wh_cnt = n_wh;
            r.rm_cnt = n_rm; r.wm_cnt = n_wm; r.wb_cnt = n_wb;
            pending.push_back(r);
        endfunction

        // Compare one result item with the oldest prediction.
        function void check_result(logic [RES_W-1:0] data);
            access_result_t got, exp;
            got = data[RES_BITS-1:0];
            checked++;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("Unexpected result item: %h", got);
                return;
            end
            exp = pending.pop_front();
            if (got.hit) hits_seen++;
            if (got.wb) wbs_seen++;
            if (got !== exp || data[RES_W-1:RES_BITS] !== '0) begin
                errors++;
                if (errors <= 10) begin
                    $display("Mismatch at result %0d:", checked);
                    $display("  hit %b/%b way %0d/%0d wb %b/%b vtag %h/%h",
                             exp.hit, got.hit, exp.way, got.way, exp.wb, got.wb,
                             exp.vtag, got.vtag);
                    $display("  acc %0d/%0d rh %0d/%0d wh %0d/%0d",
                             exp.acc_cnt, got.acc_cnt, exp.rh_cnt, got.rh_cnt,
                             exp.wh_cnt, got.wh_cnt);
                    $display("  rm %0d/%0d wm %0d/%0d wbc %0d/%0d",
                             exp.rm_cnt, got.rm_cnt, exp.wm_cnt, got.wm_cnt,
                             exp.wb_cnt, got.wb_cnt);
                end
            end
        endfunction
    endclass

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [31:0]  s_tdata = '0;
    logic         s_tuser = 0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [RES_W-1:0] m_tdata;
    logic         psel = 0;
    logic         penable = 0;
    logic         pwrite = 0;
    logic [3:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    cache_scoreboard sb = new();
    int accesses_sent = 0;
    int configs_done = 0;
    bit stall_mode = 0;

    always begin
        #4 aclk = 1;
        #4 aclk = 0;
    end

    set_assoc_lru_cache_tags_unit dut (.*);

    // Result side: stall on a pattern that switches between phases.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
        if (!aresetn) m_tready <= 0;
        else if (!stall_mode) m_tready <= 1;
        else m_tready <= ($urandom_range(0, 3) != 0) || (($urandom & 32'h3f) == 0);
    end

    // Input side: note every accepted access.
    always @(posedge aclk)
        if (aresetn && s_tvalid && s_tready) sb.note_access(s_tuser, s_tdata);

    // Send one access and wait until it is accepted.
    task automatic send_access(bit is_wr, logic [31:0] addr);
        s_tvalid <= 1;
        s_tuser <= is_wr;
        s_tdata <= addr;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        accesses_sent++;
    endtask

    task automatic go_idle();
        s_tvalid <= 0;
    endtask

    // Wait until all results have arrived, then let the block settle.
    task automatic drain();
        go_idle();
        @(posedge aclk);
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (2 * WAYS_HW + 8) @(posedge aclk);
    endtask

    // Two-phase configuration write.
    task automatic write_reg(logic [1:0] idx, logic [3:0] value);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= {idx, 2'b00}; pwdata <= {28'h0, value};
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
        case (idx)
            REG_OFFSET_WIDTH: sb.off_reg = value;
            REG_INDEX_WIDTH:  sb.idx_reg = value;
            default:          sb.ways_reg = value;
        endcase
        configs_done++;
    endtask

    task automatic set_geometry(logic [3:0] ob, logic [3:0] ib, logic [3:0] nw);
        drain();
        write_reg(REG_OFFSET_WIDTH, ob);
        write_reg(REG_INDEX_WIDTH, ib);
        write_reg(REG_WAYS, nw);
    endtask

    // Random accesses in bursts; most reuse a small pool of tags to get hits.
    task automatic random_phase(int count);
        logic [31:0] pool [8];
        logic [31:0] addr;
        int burst;
        for (int i = 0; i < 8; i++) pool[i] = $urandom;
        while (count > 0) begin
            burst = $urandom_range(1, 20);
            while (burst > 0 && count > 0) begin
                if ($urandom_range(0, 9) < 7)
                    addr = pool[$urandom_range(0, 7)] ^ ($urandom & 32'h0000_3fff);
                else
                    addr = $urandom;
                send_access($urandom_range(0, 1), addr);
                burst--;
                count--;
            end
            if ($urandom_range(0, 2) == 0) begin
                go_idle();
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1;

        // Directed: extremes of address and both kinds, then thrash one set.
        send_access(0, 32'h0000_0000);
        send_access(1, 32'h0000_0000);
        send_access(0, 32'hffff_ffff);
        send_access(1, 32'hffff_ffff);
        send_access(0, 32'haaaa_aaaa);
        send_access(1, 32'h5555_5555);
        for (int i = 0; i < 6; i++) send_access(1, 32'(i) << 10);
        for (int i = 0; i < 6; i++) send_access(0, 32'(i) << 10);

        // Wait out every result once before going on.
        drain();
        random_phase(150);

        // Out-of-range fields and storage overflow.
        set_geometry(4'd15, 4'd15, 4'd0);
        send_access(1, 32'h1234_5678);
        send_access(0, 32'h1234_5678);
        set_geometry(4'd0, 4'd10, 4'd8);
        random_phase(150);
        set_geometry(4'd12, 4'd0, 4'd15);
        random_phase(150);
        set_geometry(4'd0, 4'd0, 4'd1);
        random_phase(120);
        set_geometry(4'd3, 4'd7, 4'd2);
        stall_mode = 1;
        random_phase(200);
        set_geometry(4'd6, 4'd4, 4'd8);
        random_phase(200);
        stall_mode = 0;
        set_geometry(4'd5, 4'd5, 4'd4);
        random_phase(170);

        drain();
        $display("Sent %0d accesses over %0d register writes; %0d hits, %0d writebacks.",
                 accesses_sent, configs_done, sb.hits_seen, sb.wbs_seen);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("set_assoc_lru_cache_tags_unit test passed");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.errors, sb.pending.size());
            $display("set_assoc_lru_cache_tags_unit test failed");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #20ms;
        $display("set_assoc_lru_cache_tags_unit test failed");
        $finish;
    end

endmodule

/* sim.f */
src/salc_pkg.sv
src/salc_ram.sv
src/set_assoc_lru_cache_tags_unit.sv
src/salc_checker.sv
bench/set_assoc_lru_cache_tags_unit_test.sv
